[design/nsf_pkg.sv]
// ----------------------------------------------------------------------------
// nsf_pkg: shared types and constants for the NMEA sentence framer
// Character codes, default sizes, parse phases and the item/result structs.
// ----------------------------------------------------------------------------
package nsf_pkg;

   localparam int unsigned DEFAULT_MAX_SENTENCES = 64;
   localparam int unsigned DEFAULT_MAX_COMMAS    = 64;
   localparam int unsigned DEFAULT_OFFSET_BITS   = 16;

   localparam int unsigned FIELD_W = 16;
   localparam int unsigned COUNT_W = 7;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   localparam logic [2:0] HEADER_BYTES = 3'd5;
   localparam int unsigned BODY_GAP    = 6;   // '$' plus five header bytes

   typedef enum logic [2:0] {
      PH_DOLLAR,
      PH_HEADER,
      PH_BODY,
      PH_STAR,
      PH_HEX1,
      PH_CR,
      PH_LF,
      PH_HALT
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic               sentence_found;
      logic [FIELD_W-1:0] header_offset;
      logic [FIELD_W-1:0] body_offset;
      logic [FIELD_W-1:0] body_length;
      logic [FIELD_W-1:0] checksum_offset;
      logic               stream_done;
      logic [COUNT_W-1:0] sentence_count;
   } result_type;

   function automatic logic is_hex(input logic [7:0] b);
      logic digit;
      logic upper;
      logic lower;
      digit = (b >= 8'h30) && (b <= 8'h39);
      upper = (b >= 8'h41) && (b <= 8'h46);
      lower = (b >= 8'h61) && (b <= 8'h66);
      return digit || upper || lower;
   endfunction

endpackage

[design/nsf_if.sv]
// ----------------------------------------------------------------------------
// nsf_if: valid/ready channels of the NMEA sentence framer
// nsf_req_if carries stream bytes in, nsf_rsp_if carries framing results out.
// ----------------------------------------------------------------------------
interface nsf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nsf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       sentence_found;
   logic [nsf_pkg::FIELD_W-1:0] header_offset;
   logic [nsf_pkg::FIELD_W-1:0] body_offset;
   logic [nsf_pkg::FIELD_W-1:0] body_length;
   logic [nsf_pkg::FIELD_W-1:0] checksum_offset;
   logic                       stream_done;
   logic [nsf_pkg::COUNT_W-1:0] sentence_count;

   modport source (output valid, output sentence_found, output header_offset,
                   output body_offset, output body_length, output checksum_offset,
                   output stream_done, output sentence_count, input ready);
   modport sink   (input valid, input sentence_found, input header_offset,
                   input body_offset, input body_length, input checksum_offset,
                   input stream_done, input sentence_count, output ready);
endinterface

[design/nsf_in_stage.sv]
// ----------------------------------------------------------------------------
// nsf_in_stage: input register
// Holds one accepted byte until the parser takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module nsf_in_stage (
   input  logic              clock,
   input  logic              reset,
   nsf_req_if.sink           req_if,
   output logic              item_valid,
   output nsf_pkg::item_type item,
   input  logic              item_take
);
   import nsf_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_if.ready = !valid_ff || item_take;
   assign accept       = req_if.valid && req_if.ready;
   assign valid_in     = accept || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte <= req_if.data_byte;
         item_ff.last_byte <= req_if.last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/nsf_parser.sv]
// ----------------------------------------------------------------------------
// nsf_parser: sentence framing state machine
// One parse step per byte; builds the result for a closing LF or a last byte.
// ----------------------------------------------------------------------------
module nsf_parser #(
   parameter int unsigned MAX_SENTENCES = nsf_pkg::DEFAULT_MAX_SENTENCES,
   parameter int unsigned MAX_COMMAS    = nsf_pkg::DEFAULT_MAX_COMMAS,
   parameter int unsigned OFFSET_BITS   = nsf_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  nsf_pkg::item_type   item,
   output logic                item_take,
   input  logic                out_free,
   output logic                result_valid,
   output nsf_pkg::result_type result
);
   import nsf_pkg::*;

   localparam int unsigned CW      = $clog2(MAX_SENTENCES + 1);
   localparam int unsigned CNT_EXT = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int unsigned EXT_W   = (OFFSET_BITS + 1 > FIELD_W) ? OFFSET_BITS + 1 : FIELD_W;
   localparam logic [7:0]  COMMA_LIMIT = 8'(MAX_COMMAS);
   localparam logic [CW-1:0] SENT_LIMIT = CW'(MAX_SENTENCES);

   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [2:0]             hdr_ff, hdr_in;
   logic [6:0]             comma_ff, comma_in;
   logic [OFFSET_BITS-1:0] star_ff, star_in;
   logic [CW-1:0]          found_ff, found_in;

   logic [7:0]             b;
   logic                   found;
   logic                   emit;
   logic                   do_body;
   logic [6:0]             comma_inc;
   logic [CW-1:0]          found_inc;
   logic [CNT_EXT-1:0]     count_ext;
   logic [EXT_W-1:0]       hdr_ext;
   logic [EXT_W-1:0]       body_ext;
   logic [OFFSET_BITS-1:0] len_raw;
   logic [EXT_W-1:0]       len_ext;
   logic [EXT_W-1:0]       star_ext;

   assign b         = item.data_byte;
   assign comma_inc = comma_ff + 7'd1;
   assign found_inc = found_ff + CW'(1);

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      hdr_in   = hdr_ff;
      comma_in = comma_ff;
      star_in  = star_ff;
      found_in = found_ff;
      found    = 1'b0;
      do_body  = 1'b0;

      unique case (phase_ff)
         PH_DOLLAR: begin
            if (b == CHAR_DOLLAR) begin
               start_in = pos_ff;
               hdr_in   = HEADER_BYTES;
               phase_in = PH_HEADER;
            end else begin
               phase_in = PH_HALT;
            end
         end
         PH_HEADER: begin
            hdr_in = hdr_ff - 3'd1;
            if (hdr_in == 3'd0) begin
               comma_in = 7'd0;
               phase_in = PH_BODY;
            end
         end
         PH_BODY: do_body = 1'b1;
         PH_STAR: begin
            if (is_hex(b)) phase_in = PH_HEX1;
            else           do_body  = 1'b1;
         end
         PH_HEX1: begin
            if (is_hex(b)) phase_in = PH_CR;
            else           do_body  = 1'b1;
         end
         PH_CR:   phase_in = (b == CHAR_CR) ? PH_LF : PH_HALT;
         PH_LF: begin
            if (b == CHAR_LF) begin
               found    = 1'b1;
               found_in = found_inc;
               phase_in = (found_inc >= SENT_LIMIT) ? PH_HALT : PH_DOLLAR;
            end else begin
               phase_in = PH_HALT;
            end
         end
         default: phase_in = PH_HALT;
      endcase

      // a failed checksum digit falls back to an ordinary body byte
      if (do_body) begin
         if (b == CHAR_COMMA) begin
            comma_in = comma_inc;
            if ({1'b0, comma_inc} >= COMMA_LIMIT || comma_inc == 7'd0)
               phase_in = PH_DOLLAR;
            else
               phase_in = PH_BODY;
         end else if (b == CHAR_STAR) begin
            star_in  = pos_ff;
            phase_in = PH_STAR;
         end else begin
            phase_in = PH_BODY;
         end
      end
   end

   assign pos_in    = pos_ff + OFFSET_BITS'(1);
   assign emit      = found || item.last_byte;
   assign item_take = item_valid && (out_free || !emit);
   assign result_valid = item_take && emit;

   assign count_ext = CNT_EXT'(found_in);
   assign hdr_ext   = EXT_W'(start_ff);
   assign body_ext  = EXT_W'(start_ff) + EXT_W'(BODY_GAP);
   assign len_raw   = star_ff - start_ff - OFFSET_BITS'(BODY_GAP);
   assign len_ext   = EXT_W'(len_raw);
   assign star_ext  = EXT_W'(star_ff);

   always_comb begin
      result.sentence_found  = found;
      result.header_offset   = found ? hdr_ext[FIELD_W-1:0]  : '0;
      result.body_offset     = found ? body_ext[FIELD_W-1:0] : '0;
      result.body_length     = found ? len_ext[FIELD_W-1:0]  : '0;
      result.checksum_offset = found ? star_ext[FIELD_W-1:0] : '0;
      result.stream_done     = item.last_byte;
      result.sentence_count  = count_ext[COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset || (item_take && item.last_byte)) begin
         phase_ff <= PH_DOLLAR;
         pos_ff   <= '0;
         start_ff <= '0;
         hdr_ff   <= '0;
         comma_ff <= '0;
         star_ff  <= '0;
         found_ff <= '0;
      end else if (item_take) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         hdr_ff   <= hdr_in;
         comma_ff <= comma_in;
         star_ff  <= star_in;
         found_ff <= found_in;
      end
   end

`ifndef SYNTHESIS
   a_result_reason: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (result.sentence_found || result.stream_done))
      else $error("result without a sentence or stream end");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.last_byte) |=>
         (phase_ff == PH_DOLLAR && pos_ff == '0 && found_ff == '0))
      else $error("parser not back to start after last byte");

   a_found_bound: assert property (@(posedge clock) disable iff (reset)
      found_ff <= SENT_LIMIT)
      else $error("sentence tally beyond limit");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HEADER) |-> (hdr_ff != 3'd0 && hdr_ff <= HEADER_BYTES))
      else $error("header countdown out of range");
`endif

endmodule

[design/nsf_out_stage.sv]
// ----------------------------------------------------------------------------
// nsf_out_stage: result register
// Holds one result until taken; reloads in the cycle it is taken.
// ----------------------------------------------------------------------------
module nsf_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                result_valid,
   input  nsf_pkg::result_type result,
   output logic                out_free,
   nsf_rsp_if.source           rsp_if
);
   import nsf_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_if.ready;
   assign valid_in = result_valid || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_if.valid           = valid_ff;
   assign rsp_if.sentence_found  = result_ff.sentence_found;
   assign rsp_if.header_offset   = result_ff.header_offset;
   assign rsp_if.body_offset     = result_ff.body_offset;
   assign rsp_if.body_length     = result_ff.body_length;
   assign rsp_if.checksum_offset = result_ff.checksum_offset;
   assign rsp_if.stream_done     = result_ff.stream_done;
   assign rsp_if.sentence_count  = result_ff.sentence_count;

endmodule

[design/nmea_sentence_framer.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_framer: NMEA-style sentence framer, top level
// Input register, one-step parser and result register.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock unless a byte that gives a result must
// wait. While a result waits on rsp_if, bytes that give no result are still
// taken; a byte that gives one waits in the input register until the result
// register can be refilled. A byte is held in the input register, parsed, and
// its result, if any, is held in the result register and valid on rsp_if. The
// rate of one byte per cycle is set by the single parse step between the input
// and result registers. A result appears for the LF that closes a sentence and
// for the byte marked last_byte, after which the parser starts afresh; bytes
// that do neither produce no result.
module nmea_sentence_framer #(
   parameter int unsigned MAX_SENTENCES = nsf_pkg::DEFAULT_MAX_SENTENCES,
   parameter int unsigned MAX_COMMAS    = nsf_pkg::DEFAULT_MAX_COMMAS,
   parameter int unsigned OFFSET_BITS   = nsf_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic       clock,
   input  logic       reset,
   nsf_req_if.sink    req_if,
   nsf_rsp_if.source  rsp_if
);
   import nsf_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       item_take;
   logic       out_free;
   logic       result_valid;
   result_type result;

   nsf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   nsf_parser #(
      .MAX_SENTENCES (MAX_SENTENCES),
      .MAX_COMMAS    (MAX_COMMAS),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid),
      .item         (item),
      .item_take    (item_take),
      .out_free     (out_free),
      .result_valid (result_valid),
      .result       (result)
   );

   nsf_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .out_free     (out_free),
      .rsp_if       (rsp_if)
   );

endmodule
